// File: design/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CsrPressSens = 3'd0;
   localparam csr_index_type CsrPressOff  = 3'd1;
   localparam csr_index_type CsrSensTco   = 3'd2;
   localparam csr_index_type CsrOffTco    = 3'd3;
   localparam csr_index_type CsrTempRef   = 3'd4;
   localparam csr_index_type CsrTempSens  = 3'd5;

   localparam int TempRef  = 2000;
   localparam int TempLow  = -1500;
   localparam int TempMin  = -4000;
   localparam int TempMax  = 8500;
   localparam int PressMin = 1000;
   localparam int PressMax = 120000;

   // x / 100 for 0 <= x <= 8500: (x * 5243) >> 19
   localparam logic [12:0] DivRecip   = 13'd5243;
   localparam int          RecipShift = 19;

   typedef struct packed {
      logic [15:0] press_sens;
      logic [15:0] press_off;
      logic [15:0] sens_tco;
      logic [15:0] off_tco;
      logic [15:0] temp_ref;
      logic [15:0] temp_sens;
   } cal_type;

   localparam cal_type CalReset = '{
      press_sens: 16'd40127,
      press_off:  16'd36924,
      sens_tco:   16'd23317,
      off_tco:    16'd23282,
      temp_ref:   16'd33464,
      temp_sens:  16'd28312
   };

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } sample_type;

   typedef struct packed {
      logic [23:0]        d1;
      logic signed [18:0] temp1;
      logic signed [18:0] t2;
      logic signed [34:0] off1;
      logic signed [33:0] sens1;
      logic [34:0]        sq_ref;
      logic [34:0]        sq_low;
      logic               below_ref;
      logic               below_low;
   } first_order_type;

   typedef struct packed {
      logic [23:0]        d1;
      logic signed [14:0] temp_c;
      logic               temp_clamped;
      logic signed [39:0] off;
      logic signed [39:0] sens;
   } comp_type;

   typedef struct packed {
      logic signed [14:0] temp_centi;
      logic signed [7:0]  temp_whole;
      logic [16:0]        pressure_pa;
      logic               clamped;
   } result_type;

endpackage

`default_nettype wire

// File: design/bpc_req_if.sv
`default_nettype none

interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] raw_pressure;
   logic [23:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

// File: design/bpc_rsp_if.sv
`default_nettype none

interface bpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temp_centi;
   logic signed [7:0]  temp_whole;
   logic [16:0]        pressure_pa;
   logic               clamped;

   modport source (output valid, output temp_centi, output temp_whole,
                   output pressure_pa, output clamped, input ready);
   modport sink (input valid, input temp_centi, input temp_whole,
                 input pressure_pa, input clamped, output ready);
endinterface

`default_nettype wire

// File: design/bpc_csr_if.sv
`default_nettype none

interface bpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/bpc_csr.sv
`default_nettype none

module bpc_csr (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  bpc_pkg::csr_index_type csr_index,
   input  wire [15:0]            csr_data,
   output bpc_pkg::cal_type      cal
);

   bpc_pkg::cal_type cal_ff, cal_in;

   assign csr_ready = 1'b1;
   assign cal       = cal_ff;

   always_comb begin
      cal_in = cal_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bpc_pkg::CsrPressSens: cal_in.press_sens = csr_data;
            bpc_pkg::CsrPressOff:  cal_in.press_off  = csr_data;
            bpc_pkg::CsrSensTco:   cal_in.sens_tco   = csr_data;
            bpc_pkg::CsrOffTco:    cal_in.off_tco    = csr_data;
            bpc_pkg::CsrTempRef:   cal_in.temp_ref   = csr_data;
            bpc_pkg::CsrTempSens:  cal_in.temp_sens  = csr_data;
            default: begin
               // drop writes beyond the register list
               cal_in = cal_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= bpc_pkg::CalReset;
      end else begin
         cal_ff <= cal_in;
      end
   end

endmodule

`default_nettype wire

// File: design/bpc_temp.sv
`default_nettype none

module bpc_temp (
   input  wire                         clock,
   input  wire                         reset,
   input  bpc_pkg::cal_type            cal,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  bpc_pkg::sample_type         in_data,
   output logic                        out_valid,
   input  wire                         out_ready,
   output bpc_pkg::first_order_type    out_data
);

   logic [3:0] valid_ff, valid_in, adv;

   logic [23:0]        s1_d1_ff;
   logic signed [24:0] s1_dt_ff, s1_dt_in;

   logic [23:0]        s2_d1_ff;
   logic signed [41:0] s2_p_temp_ff, s2_p_temp_in;
   logic signed [41:0] s2_p_off_ff, s2_p_off_in;
   logic signed [41:0] s2_p_sens_ff, s2_p_sens_in;
   logic signed [49:0] s2_dsq_ff, s2_dsq_in;

   logic [23:0]        s3_d1_ff;
   logic signed [18:0] s3_temp1_ff, s3_temp1_in;
   logic signed [18:0] s3_t2_ff, s3_t2_in;
   logic signed [34:0] s3_off1_ff, s3_off1_in;
   logic signed [33:0] s3_sens1_ff, s3_sens1_in;

   bpc_pkg::first_order_type s4_ff, s4_in;

   logic signed [19:0] diff_ref, diff_low;
   logic signed [39:0] sq_ref_full, sq_low_full;

   always_comb begin
      adv[3] = !valid_ff[3] || out_ready;
      adv[2] = !valid_ff[2] || adv[3];
      adv[1] = !valid_ff[1] || adv[2];
      adv[0] = !valid_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[3];
   assign out_data  = s4_ff;

   always_comb begin
      valid_in = valid_ff;
      if (adv[0]) valid_in[0] = in_valid;
      if (adv[1]) valid_in[1] = valid_ff[0];
      if (adv[2]) valid_in[2] = valid_ff[1];
      if (adv[3]) valid_in[3] = valid_ff[2];
   end

   // temperature difference to the reference
   assign s1_dt_in = signed'({1'b0, in_data.raw_temperature})
                   - signed'({1'b0, cal.temp_ref, 8'h00});

   assign s2_p_temp_in = s1_dt_ff * signed'({1'b0, cal.temp_sens});
   assign s2_p_off_in  = s1_dt_ff * signed'({1'b0, cal.off_tco});
   assign s2_p_sens_in = s1_dt_ff * signed'({1'b0, cal.sens_tco});
   assign s2_dsq_in    = s1_dt_ff * s1_dt_ff;

   assign s3_temp1_in = 19'(s2_p_temp_ff >>> 23) + 19'(bpc_pkg::TempRef);
   assign s3_off1_in  = signed'({3'b000, cal.press_off, 16'h0000}) + 35'(s2_p_off_ff >>> 7);
   assign s3_sens1_in = signed'({3'b000, cal.press_sens, 15'h0000}) + 34'(s2_p_sens_ff >>> 8);
   assign s3_t2_in    = signed'({1'b0, s2_dsq_ff[48:31]});

   assign diff_ref    = 20'(s3_temp1_ff) - 20'(bpc_pkg::TempRef);
   assign diff_low    = 20'(s3_temp1_ff) - 20'(bpc_pkg::TempLow);
   assign sq_ref_full = diff_ref * diff_ref;
   assign sq_low_full = diff_low * diff_low;

   always_comb begin
      s4_in.d1        = s3_d1_ff;
      s4_in.temp1     = s3_temp1_ff;
      s4_in.t2        = s3_t2_ff;
      s4_in.off1      = s3_off1_ff;
      s4_in.sens1     = s3_sens1_ff;
      s4_in.sq_ref    = sq_ref_full[34:0];
      s4_in.sq_low    = sq_low_full[34:0];
      s4_in.below_ref = s3_temp1_ff < 19'(bpc_pkg::TempRef);
      s4_in.below_low = s3_temp1_ff < 19'(bpc_pkg::TempLow);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_d1_ff <= in_data.raw_pressure;
         s1_dt_ff <= s1_dt_in;
      end
      if (adv[1]) begin
         s2_d1_ff     <= s1_d1_ff;
         s2_p_temp_ff <= s2_p_temp_in;
         s2_p_off_ff  <= s2_p_off_in;
         s2_p_sens_ff <= s2_p_sens_in;
         s2_dsq_ff    <= s2_dsq_in;
      end
      if (adv[2]) begin
         s3_d1_ff    <= s2_d1_ff;
         s3_temp1_ff <= s3_temp1_in;
         s3_t2_ff    <= s3_t2_in;
         s3_off1_ff  <= s3_off1_in;
         s3_sens1_ff <= s3_sens1_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
   end

endmodule

`default_nettype wire

// File: design/bpc_corr.sv
`default_nettype none

module bpc_corr (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  bpc_pkg::first_order_type in_data,
   output logic                     out_valid,
   input  wire                      out_ready,
   output bpc_pkg::comp_type        out_data
);

   logic [1:0] valid_ff, valid_in, adv;

   logic [37:0] five_sq, seven_sq;
   logic [38:0] eleven_sq;

   logic [23:0]        s5_d1_ff;
   logic signed [19:0] s5_temp2_ff, s5_temp2_in;
   logic signed [34:0] s5_off1_ff;
   logic signed [33:0] s5_sens1_ff;
   logic [37:0]        s5_off2_ff, s5_off2_in;
   logic [37:0]        s5_sens2_ff, s5_sens2_in;

   bpc_pkg::comp_type s6_ff, s6_in;

   always_comb begin
      adv[1] = !valid_ff[1] || out_ready;
      adv[0] = !valid_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[1];
   assign out_data  = s6_ff;

   always_comb begin
      valid_in = valid_ff;
      if (adv[0]) valid_in[0] = in_valid;
      if (adv[1]) valid_in[1] = valid_ff[0];
   end

   assign five_sq   = {1'b0, in_data.sq_ref, 2'b00} + 38'(in_data.sq_ref);
   assign seven_sq  = {in_data.sq_low, 3'b000} - 38'(in_data.sq_low);
   assign eleven_sq = {1'b0, in_data.sq_low, 3'b000} + 39'({in_data.sq_low, 1'b0})
                    + 39'(in_data.sq_low);

   always_comb begin
      s5_temp2_in = 20'(in_data.temp1);
      s5_off2_in  = '0;
      s5_sens2_in = '0;
      if (in_data.below_ref) begin
         s5_temp2_in = 20'(in_data.temp1) - 20'(in_data.t2);
         s5_off2_in  = 38'(five_sq[37:1]);
         s5_sens2_in = 38'(five_sq[37:2]);
         if (in_data.below_low) begin
            s5_off2_in  = 38'(five_sq[37:1]) + seven_sq;
            s5_sens2_in = 38'(five_sq[37:2]) + eleven_sq[38:1];
         end
      end
   end

   always_comb begin
      s6_in.d1           = s5_d1_ff;
      s6_in.off          = 40'(s5_off1_ff) - signed'({2'b00, s5_off2_ff});
      s6_in.sens         = 40'(s5_sens1_ff) - signed'({2'b00, s5_sens2_ff});
      s6_in.temp_clamped = 1'b1;
      if (s5_temp2_ff < 20'(bpc_pkg::TempMin)) begin
         s6_in.temp_c = 15'(bpc_pkg::TempMin);
      end else if (s5_temp2_ff > 20'(bpc_pkg::TempMax)) begin
         s6_in.temp_c = 15'(bpc_pkg::TempMax);
      end else begin
         s6_in.temp_c       = 15'(s5_temp2_ff);
         s6_in.temp_clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s5_d1_ff    <= in_data.d1;
         s5_temp2_ff <= s5_temp2_in;
         s5_off1_ff  <= in_data.off1;
         s5_sens1_ff <= in_data.sens1;
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
      end
      if (adv[1]) begin
         s6_ff <= s6_in;
      end
   end

endmodule

`default_nettype wire

// File: design/bpc_press.sv
`default_nettype none

module bpc_press (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  bpc_pkg::comp_type   in_data,
   output logic                out_valid,
   input  wire                 out_ready,
   output bpc_pkg::result_type out_data
);

   logic [3:0] valid_ff, valid_in, adv;

   logic signed [14:0] neg_c;
   logic [13:0]        temp_abs;

   logic [43:0]        s7_pl_ff, s7_pl_in;
   logic signed [44:0] s7_ph_ff, s7_ph_in;
   logic [26:0]        s7_rq_ff, s7_rq_in;
   logic               s7_neg_ff;
   logic signed [14:0] s7_temp_c_ff;
   logic               s7_tclamp_ff;
   logic signed [39:0] s7_off_ff;

   logic signed [63:0] ph_ext;
   logic signed [7:0]  quot;

   logic signed [63:0] s8_prod_ff, s8_prod_in;
   logic signed [7:0]  s8_whole_ff, s8_whole_in;
   logic signed [14:0] s8_temp_c_ff;
   logic               s8_tclamp_ff;
   logic signed [39:0] s8_off_ff;

   logic signed [43:0] diff;
   logic signed [28:0] s9_press_ff, s9_press_in;
   logic signed [7:0]  s9_whole_ff;
   logic signed [14:0] s9_temp_c_ff;
   logic               s9_tclamp_ff;

   bpc_pkg::result_type s10_ff, s10_in;

   always_comb begin
      adv[3] = !valid_ff[3] || out_ready;
      adv[2] = !valid_ff[2] || adv[3];
      adv[1] = !valid_ff[1] || adv[2];
      adv[0] = !valid_ff[0] || adv[1];
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[3];
   assign out_data  = s10_ff;

   always_comb begin
      valid_in = valid_ff;
      if (adv[0]) valid_in[0] = in_valid;
      if (adv[1]) valid_in[1] = valid_ff[0];
      if (adv[2]) valid_in[2] = valid_ff[1];
      if (adv[3]) valid_in[3] = valid_ff[2];
   end

   // split sens into an unsigned low half and a signed high half
   assign s7_pl_in = in_data.d1 * in_data.sens[19:0];
   assign s7_ph_in = signed'({1'b0, in_data.d1}) * signed'(in_data.sens[39:20]);

   assign neg_c    = -in_data.temp_c;
   assign temp_abs = in_data.temp_c[14] ? 14'(neg_c) : 14'(in_data.temp_c);
   assign s7_rq_in = temp_abs * bpc_pkg::DivRecip;

   assign ph_ext     = 64'(s7_ph_ff);
   assign s8_prod_in = (ph_ext <<< 20) + signed'({20'd0, s7_pl_ff});
   assign quot       = signed'(s7_rq_ff[bpc_pkg::RecipShift + 7:bpc_pkg::RecipShift]);
   assign s8_whole_in = s7_neg_ff ? -quot : quot;

   assign diff        = 44'(s8_prod_ff >>> 21) - 44'(s8_off_ff);
   assign s9_press_in = 29'(diff >>> 15);

   always_comb begin
      s10_in.temp_centi = s9_temp_c_ff;
      s10_in.temp_whole = s9_whole_ff;
      s10_in.clamped    = 1'b1;
      if (s9_press_ff < 29'(bpc_pkg::PressMin)) begin
         s10_in.pressure_pa = 17'(bpc_pkg::PressMin);
      end else if (s9_press_ff > 29'(bpc_pkg::PressMax)) begin
         s10_in.pressure_pa = 17'(bpc_pkg::PressMax);
      end else begin
         s10_in.pressure_pa = 17'(s9_press_ff);
         s10_in.clamped     = s9_tclamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s7_pl_ff     <= s7_pl_in;
         s7_ph_ff     <= s7_ph_in;
         s7_rq_ff     <= s7_rq_in;
         s7_neg_ff    <= in_data.temp_c[14];
         s7_temp_c_ff <= in_data.temp_c;
         s7_tclamp_ff <= in_data.temp_clamped;
         s7_off_ff    <= in_data.off;
      end
      if (adv[1]) begin
         s8_prod_ff   <= s8_prod_in;
         s8_whole_ff  <= s8_whole_in;
         s8_temp_c_ff <= s7_temp_c_ff;
         s8_tclamp_ff <= s7_tclamp_ff;
         s8_off_ff    <= s7_off_ff;
      end
      if (adv[2]) begin
         s9_press_ff  <= s9_press_in;
         s9_whole_ff  <= s8_whole_ff;
         s9_temp_c_ff <= s8_temp_c_ff;
         s9_tclamp_ff <= s8_tclamp_ff;
      end
      if (adv[3]) begin
         s10_ff <= s10_in;
      end
   end

endmodule

`default_nettype wire

// File: design/barometric_pressure_compensation_top.sv
// Barometric pressure and temperature compensation, second-order scheme.
// req_ch carries one raw pressure and one raw temperature reading per item;
// rsp_ch returns one item per request, in order: temperature in 0.01 C,
// whole degrees truncated toward zero, pressure in Pa and a saturation flag.
// csr_ch writes the six calibration words by index 0..5; other indexes are
// dropped. csr_ch is always ready; write it only while the pipeline is empty.
// Pipeline: ten register stages (dt products, squares, then the pressure
// product split into two partial products). Throughput: one item per cycle
// while rsp_ch is ready; back-pressure on rsp_ch stalls the stages.
// Stall: every stage holds while the stage after it is full and blocked;
// req_ch keeps accepting until all ten stages hold an item.
// Reset: synchronous, clears all stage valid bits and loads the factory
// default calibration words.
`default_nettype none

module barometric_pressure_compensation_top (
   input wire        clock,
   input wire        reset,
   bpc_req_if.sink   req_ch,
   bpc_rsp_if.source rsp_ch,
   bpc_csr_if.sink   csr_ch
);

   bpc_pkg::cal_type         cal;
   bpc_pkg::sample_type      sample;
   bpc_pkg::first_order_type first_data;
   bpc_pkg::comp_type        comp_data;
   bpc_pkg::result_type      result;

   logic first_valid, first_ready;
   logic comp_valid, comp_ready;

   assign sample.raw_pressure    = req_ch.raw_pressure;
   assign sample.raw_temperature = req_ch.raw_temperature;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cal       (cal)
   );

   bpc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (sample),
      .out_valid (first_valid),
      .out_ready (first_ready),
      .out_data  (first_data)
   );

   bpc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_valid),
      .in_ready  (first_ready),
      .in_data   (first_data),
      .out_valid (comp_valid),
      .out_ready (comp_ready),
      .out_data  (comp_data)
   );

   bpc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (comp_valid),
      .in_ready  (comp_ready),
      .in_data   (comp_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (result)
   );

   assign rsp_ch.temp_centi  = result.temp_centi;
   assign rsp_ch.temp_whole  = result.temp_whole;
   assign rsp_ch.pressure_pa = result.pressure_pa;
   assign rsp_ch.clamped     = result.clamped;

endmodule

`default_nettype wire

// File: design/bpc_checker.sv
`default_nettype none

module bpc_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire signed [14:0] temp_centi,
   input wire signed [7:0]  temp_whole,
   input wire [16:0]        pressure_pa,
   input wire               clamped
);

   logic signed [31:0] centi_w, whole_x100;
   logic               at_bound;

   assign centi_w    = 32'(temp_centi);
   assign whole_x100 = 32'(temp_whole) * 32'sd100;
   assign at_bound   = (centi_w == bpc_pkg::TempMin) || (centi_w == bpc_pkg::TempMax)
                    || (32'(pressure_pa) == bpc_pkg::PressMin)
                    || (32'(pressure_pa) == bpc_pkg::PressMax);

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (centi_w >= bpc_pkg::TempMin) && (centi_w <= bpc_pkg::TempMax))
      else $error("temp_centi out of range");

   a_press_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(pressure_pa) >= bpc_pkg::PressMin)
                 && (32'(pressure_pa) <= bpc_pkg::PressMax))
      else $error("pressure_pa out of range");

   a_whole_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((centi_w >= 0) ?
                       (whole_x100 <= centi_w && centi_w - whole_x100 < 100) :
                       (whole_x100 >= centi_w && whole_x100 - centi_w < 100)))
      else $error("temp_whole does not match temp_centi");

   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !at_bound |-> !clamped)
      else $error("clamped set without a saturated field");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .temp_centi  (rsp_ch.temp_centi),
   .temp_whole  (rsp_ch.temp_whole),
   .pressure_pa (rsp_ch.pressure_pa),
   .clamped     (rsp_ch.clamped)
);

`default_nettype wire

// File: dv/barometric_pressure_compensation_top_tb.sv
`default_nettype none

module barometric_pressure_compensation_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam bpc_pkg::csr_index_type CsrPastLast = 3'd6;
   localparam bpc_pkg::csr_index_type CsrTopIndex = 3'd7;
   localparam int            CycleLimit    = 400000;
   localparam int            HoldOffCycles = 300;
   localparam int            DrainCycles   = 20;
   localparam int            PhaseItems    = 200;
   localparam logic [23:0]   RawMax        = 24'hFFFFFF;

   logic clock;
   logic reset;

   bpc_req_if req_ch ();
   bpc_rsp_if rsp_ch ();
   bpc_csr_if csr_ch ();

   barometric_pressure_compensation_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bpc_pkg::cal_type    cal_model;
   bpc_pkg::result_type awaited_results[$];
   bpc_pkg::result_type want_result;
   int         mismatch_count;
   int         cycle_count;
   bit         no_idle;
   logic       hold_active;
   event       hold_off_start;

   always #6 clock = ~clock;

   function automatic bpc_pkg::result_type compensate(input logic [23:0] praw,
                                                      input logic [23:0] traw,
                                                      input bpc_pkg::cal_type cal);
      longint     d1, d2, c1, c2, c3, c4, c5, c6;
      longint     dt, temp, off, sens, t2, off2, sens2, press, a, b, sq, sq2, whole;
      logic       sat;
      bpc_pkg::result_type r;
      d1 = longint'(praw);
      d2 = longint'(traw);
      c1 = longint'(cal.press_sens);
      c2 = longint'(cal.press_off);
      c3 = longint'(cal.sens_tco);
      c4 = longint'(cal.off_tco);
      c5 = longint'(cal.temp_ref);
      c6 = longint'(cal.temp_sens);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      sat = 1'b0;
      dt = d2 - c5 * 256;
      temp = bpc_pkg::TempRef + ((dt * c6) >>> 23);
      off = c2 * 65536 + ((c4 * dt) >>> 7);
      sens = c1 * 32768 + ((c3 * dt) >>> 8);
      if (temp < bpc_pkg::TempRef) begin
         a = temp - bpc_pkg::TempRef;
         sq = a * a;
         t2 = (dt * dt) >>> 31;
         off2 = (5 * sq) >>> 1;
         sens2 = (5 * sq) >>> 2;
         if (temp < bpc_pkg::TempLow) begin
            b = temp - bpc_pkg::TempLow;
            sq2 = b * b;
            off2 = off2 + 7 * sq2;
            sens2 = sens2 + ((11 * sq2) >>> 1);
         end
      end
      temp = temp - t2;
      off = off - off2;
      sens = sens - sens2;
      press = (((d1 * sens) >>> 21) - off) >>> 15;
      if (temp < bpc_pkg::TempMin) begin
         temp = longint'(bpc_pkg::TempMin);
         sat = 1'b1;
      end
      if (temp > bpc_pkg::TempMax) begin
         temp = longint'(bpc_pkg::TempMax);
         sat = 1'b1;
      end
      if (press < bpc_pkg::PressMin) begin
         press = longint'(bpc_pkg::PressMin);
         sat = 1'b1;
      end
      if (press > bpc_pkg::PressMax) begin
         press = longint'(bpc_pkg::PressMax);
         sat = 1'b1;
      end
      whole = temp / 100;
      r.temp_centi = temp[14:0];
      r.temp_whole = whole[7:0];
      r.pressure_pa = press[16:0];
      r.clamped = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic write_cal(input bpc_pkg::csr_index_type idx, input logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         bpc_pkg::CsrPressSens: cal_model.press_sens = val;
         bpc_pkg::CsrPressOff:  cal_model.press_off = val;
         bpc_pkg::CsrSensTco:   cal_model.sens_tco = val;
         bpc_pkg::CsrOffTco:    cal_model.off_tco = val;
         bpc_pkg::CsrTempRef:   cal_model.temp_ref = val;
         bpc_pkg::CsrTempSens:  cal_model.temp_sens = val;
         default: ;
      endcase
   endtask

   task automatic load_cal(input bpc_pkg::cal_type c);
      write_cal(bpc_pkg::CsrPressSens, c.press_sens);
      write_cal(bpc_pkg::CsrPressOff, c.press_off);
      write_cal(bpc_pkg::CsrSensTco, c.sens_tco);
      write_cal(bpc_pkg::CsrOffTco, c.off_tco);
      write_cal(bpc_pkg::CsrTempRef, c.temp_ref);
      write_cal(bpc_pkg::CsrTempSens, c.temp_sens);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_reading(input logic [23:0] p, input logic [23:0] t);
      while (!no_idle && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_pressure <= p;
      req_ch.raw_temperature <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      awaited_results.push_back(compensate(p, t, cal_model));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_default_corners();
      send_reading(24'd9085466, 24'd8569150);
      send_reading(24'd9085466, 24'd8566784);
      send_reading(24'd9085466, 24'd8566783);
      send_reading(24'd9085466, 24'd7529767);
      send_reading(24'd9085466, 24'd7529766);
      send_reading(24'd9085466, 24'd7000000);
      send_reading(24'd9085466, 24'd6700000);
      send_reading(24'd9085466, 24'd10492680);
      send_reading(24'd9085466, 24'd10492980);
      send_reading(24'd9085466, 24'd0);
      send_reading(24'd9085466, RawMax);
      send_reading(24'd0, 24'd8569150);
      send_reading(24'd1, 24'd8569150);
      send_reading(RawMax, 24'd8569150);
      send_reading(24'h800000, 24'd8569150);
      send_reading(24'd6000000, 24'd7529766);
      send_reading(RawMax, 24'd0);
      send_reading(24'd0, RawMax);
      send_reading(RawMax, RawMax);
      send_reading(24'd0, 24'd0);
      wait_drained();
   endtask

   task automatic sweep_corners();
      logic [23:0] tv[4];
      logic [23:0] pv[3];
      tv = '{24'd0, RawMax, 24'h800000, 24'($urandom)};
      pv = '{24'd0, RawMax, 24'h800000};
      foreach (tv[i]) begin
         foreach (pv[j]) send_reading(pv[j], tv[i]);
      end
      wait_drained();
   endtask

   task automatic test_cal_extremes();
      bpc_pkg::cal_type c;
      load_cal('0);
      sweep_corners();
      load_cal('1);
      sweep_corners();
      c = '{16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF};
      load_cal(c);
      sweep_corners();
      load_cal(bpc_pkg::CalReset);
      write_cal(CsrPastLast, 16'hFFFF);
      write_cal(CsrTopIndex, 16'h0000);
      csr_ch.valid <= 1'b0;
      sweep_corners();
   endtask

   task automatic test_backpressure();
      no_idle = 1'b1;
      -> hold_off_start;
      for (int i = 0; i < 60; i++) send_reading(24'($urandom), 24'($urandom));
      wait_drained();
      no_idle = 1'b0;
   endtask

   task automatic test_random_stream();
      bpc_pkg::cal_type c;
      longint      center;
      longint      tval;
      logic [23:0] p;
      logic [23:0] t;
      for (int phase = 0; phase < 6; phase++) begin
         no_idle = (phase == 0);
         if (phase == 0) begin
            c = bpc_pkg::CalReset;
         end else if (phase < 3) begin
            c.press_sens = bpc_pkg::CalReset.press_sens + 16'($urandom_range(16000))
                         - 16'd8000;
            c.press_off = bpc_pkg::CalReset.press_off + 16'($urandom_range(16000))
                        - 16'd8000;
            c.sens_tco = bpc_pkg::CalReset.sens_tco + 16'($urandom_range(16000))
                       - 16'd8000;
            c.off_tco = bpc_pkg::CalReset.off_tco + 16'($urandom_range(16000))
                      - 16'd8000;
            c.temp_ref = bpc_pkg::CalReset.temp_ref + 16'($urandom_range(16000))
                       - 16'd8000;
            c.temp_sens = bpc_pkg::CalReset.temp_sens + 16'($urandom_range(16000))
                        - 16'd8000;
         end else begin
            c = bpc_pkg::cal_type'({$urandom, $urandom, $urandom});
         end
         load_cal(c);
         center = longint'(cal_model.temp_ref) * 256;
         for (int i = 0; i < PhaseItems; i++) begin
            if ($urandom_range(99) < 60) begin
               tval = center + longint'($urandom_range(5000000)) - 2500000;
               if (tval < 0) tval = 0;
               if (tval > longint'(RawMax)) tval = longint'(RawMax);
               t = tval[23:0];
            end else begin
               t = 24'($urandom);
            end
            if ($urandom_range(99) < 70) p = 24'($urandom_range(12000000, 2000000));
            else p = 24'($urandom);
            send_reading(p, t);
         end
         wait_drained();
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= !hold_active && (no_idle || $urandom_range(99) >= 25);
   end

   always @(hold_off_start) begin
      hold_active <= 1'b1;
      repeat (HoldOffCycles) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result with nothing awaited");
         end else begin
            want_result = awaited_results.pop_front();
            if (rsp_ch.temp_centi !== want_result.temp_centi)
               report_mismatch($sformatf("temp_centi got %0d want %0d",
                                         rsp_ch.temp_centi, want_result.temp_centi));
            if (rsp_ch.temp_whole !== want_result.temp_whole)
               report_mismatch($sformatf("temp_whole got %0d want %0d",
                                         rsp_ch.temp_whole, want_result.temp_whole));
            if (rsp_ch.pressure_pa !== want_result.pressure_pa)
               report_mismatch($sformatf("pressure_pa got %0d want %0d",
                                         rsp_ch.pressure_pa, want_result.pressure_pa));
            if (rsp_ch.clamped !== want_result.clamped)
               report_mismatch($sformatf("clamped got %0b want %0b",
                                         rsp_ch.clamped, want_result.clamped));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("barometric_pressure_compensation_top_tb NOT OK");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      mismatch_count = 0;
      no_idle = 1'b0;
      hold_active = 1'b0;
      cal_model = bpc_pkg::CalReset;
      req_ch.valid = 1'b0;
      req_ch.raw_pressure = '0;
      req_ch.raw_temperature = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = bpc_pkg::CsrPressSens;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_corners();
      test_cal_extremes();
      test_backpressure();
      test_random_stream();
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("barometric_pressure_compensation_top_tb OK");
      end else begin
         $display("barometric_pressure_compensation_top_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
